/* src/prsw_pkg.sv */
// ----------------------------------------------------------------------------
// prsw_pkg
// Shared types and constants of the partial reliability stop-and-wait sender.
// ----------------------------------------------------------------------------
package prsw_pkg;

	// fixed field widths
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned LOST_W   = 7;

	// event codes on the input word
	localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

	// reset value of the loss limit
	localparam logic [LOST_W-1:0] MAX_LOST_RST = 7'd3;

	// result codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_NEW       = 3'd0,
		ACT_DELIVERED = 3'd1,
		ACT_LOSS_OK   = 3'd2,
		ACT_RETX      = 3'd3,
		ACT_IGNORED   = 3'd4,
		ACT_BUSY      = 3'd5
	} action_t;

	// one event held in the input stage
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              ack_number;
	} evt_t;

endpackage

/* src/prsw_in_if.sv */
// ----------------------------------------------------------------------------
// prsw_in_if
// Valid/ready channel carrying one sender event word.
// ----------------------------------------------------------------------------
interface prsw_in_if import prsw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic              ack_number;

	modport source (output valid, output mode, output ack_number, input ready);
	modport sink (input valid, input mode, input ack_number, output ready);
endinterface

/* src/prsw_out_if.sv */
// ----------------------------------------------------------------------------
// prsw_out_if
// Valid/ready channel carrying one sender result word.
// ----------------------------------------------------------------------------
interface prsw_out_if import prsw_pkg::*; ();
	logic              valid;
	logic              ready;
	action_t           action;
	logic              seq_bit_out;
	logic [LOST_W-1:0] lost_in_window;

	modport source (output valid, output action, output seq_bit_out,
		output lost_in_window, input ready);
	modport sink (input valid, input action, input seq_bit_out,
		input lost_in_window, output ready);
endinterface

/* src/prsw_in_stage.sv */
// ----------------------------------------------------------------------------
// prsw_in_stage
// Input register: captures one event word per cycle while the engine drains.
// ----------------------------------------------------------------------------
module prsw_in_stage import prsw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	prsw_in_if.sink   evt_in,
	input  logic      advance,
	output logic      valid_s1,
	output evt_t      evt_s1
);

	logic valid_s1_r;
	evt_t evt_s1_r;

	// accept when empty or when the held word moves on this cycle
	assign evt_in.ready = !valid_s1_r || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_r <= 1'b0;
		end else if (evt_in.ready) begin
			valid_s1_r <= evt_in.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (evt_in.ready && evt_in.valid) begin
			evt_s1_r.mode       <= evt_in.mode;
			evt_s1_r.ack_number <= evt_in.ack_number;
		end
	end

	assign valid_s1 = valid_s1_r;
	assign evt_s1   = evt_s1_r;

endmodule

/* src/prsw_engine.sv */
// ----------------------------------------------------------------------------
// prsw_engine
// Protocol state, event classification and the result register.
// ----------------------------------------------------------------------------
module prsw_engine import prsw_pkg::*; #(
	parameter int unsigned WINDOW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              max_lost_we,
	input  logic [LOST_W-1:0] max_lost_wdata,
	input  logic              valid_s1,
	input  evt_t              evt_s1,
	output logic              advance,
	prsw_out_if.source        res_out
);

	localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

	// protocol state
	logic              seq_bit_q;
	logic              awaiting_q;
	logic [WINDOW-1:0] window_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  lost_q;
	logic [LOST_W-1:0] max_lost_q;

	// result register
	logic              res_valid_q;
	action_t           action_q;
	logic              seq_out_q;
	logic [LOST_W-1:0] lost_out_q;

	// next values
	logic              seq_bit_d;
	logic              awaiting_d;
	logic [WINDOW-1:0] window_d;
	logic [PTR_W-1:0]  ptr_d;
	logic [CNT_W-1:0]  lost_d;
	action_t           action_d;
	logic              seq_out_d;

	logic              fire;
	logic              cur_bit;
	logic [PTR_W-1:0]  ptr_next;
	logic [CNT_W-1:0]  lost_on_loss;

	assign advance = !res_valid_q || res_out.ready;
	assign fire    = valid_s1 && advance;

	assign cur_bit      = window_q[ptr_q];
	assign ptr_next     = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
	assign lost_on_loss = cur_bit ? lost_q + CNT_W'(1) : lost_q;

	// event classification and state update
	always_comb begin
		seq_bit_d  = seq_bit_q;
		awaiting_d = awaiting_q;
		window_d   = window_q;
		ptr_d      = ptr_q;
		lost_d     = lost_q;
		action_d   = ACT_IGNORED;
		seq_out_d  = 1'b0;
		unique case (evt_s1.mode)
			MODE_SEND: begin
				if (awaiting_q) begin
					action_d = ACT_BUSY;
				end else begin
					action_d   = ACT_NEW;
					seq_out_d  = seq_bit_q;
					seq_bit_d  = !seq_bit_q;
					awaiting_d = 1'b1;
				end
			end
			MODE_ACK: begin
				if (awaiting_q && (evt_s1.ack_number == seq_bit_q)) begin
					action_d        = ACT_DELIVERED;
					window_d[ptr_q] = 1'b1;
					if (!cur_bit && (lost_q != '0)) begin
						lost_d = lost_q - CNT_W'(1);
					end
					ptr_d      = ptr_next;
					awaiting_d = 1'b0;
				end
			end
			MODE_TIMEOUT: begin
				if (awaiting_q) begin
					window_d[ptr_q] = 1'b0;
					lost_d          = lost_on_loss;
					if (LOST_W'(lost_on_loss) <= max_lost_q) begin
						action_d   = ACT_LOSS_OK;
						ptr_d      = ptr_next;
						seq_bit_d  = !seq_bit_q;
						awaiting_d = 1'b0;
					end else begin
						action_d  = ACT_RETX;
						seq_out_d = !seq_bit_q;
					end
				end
			end
			default: begin
				action_d = ACT_IGNORED;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_bit_q  <= 1'b0;
			awaiting_q <= 1'b0;
			window_q   <= '1;
			ptr_q      <= '0;
			lost_q     <= '0;
		end else if (fire) begin
			seq_bit_q  <= seq_bit_d;
			awaiting_q <= awaiting_d;
			window_q   <= window_d;
			ptr_q      <= ptr_d;
			lost_q     <= lost_d;
		end
	end

	// loss limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lost_q <= MAX_LOST_RST;
		end else if (max_lost_we) begin
			max_lost_q <= max_lost_wdata;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			action_q   <= action_d;
			seq_out_q  <= seq_out_d;
			lost_out_q <= LOST_W'(lost_d);
		end
	end

	assign res_out.valid          = res_valid_q;
	assign res_out.action         = action_q;
	assign res_out.seq_bit_out    = seq_out_q;
	assign res_out.lost_in_window = lost_out_q;

endmodule

/* src/partial_reliability_stop_wait_sender_core.sv */
// ----------------------------------------------------------------------------
// partial_reliability_stop_wait_sender_core
// Stop-and-wait sender with alternating sequence bit and a loss window.
//
// channel    dir  fields                                   width
// evt_in     in   mode, ack_number                         2, 1
// res_out    out  action, seq_bit_out, lost_in_window      3, 1, 7
// max_lost   cfg  max_lost_we, max_lost_wdata              1, 7
//
// One event per cycle while results are taken; an accepted event passes the
// input register, then one pass of the classifier into the result register.
// Reset: loss window all delivered, sequence bit zero, idle, limit of three.
// A stalled result register holds the input register, which takes one more
// event only if it is empty; ready then drops.
// ----------------------------------------------------------------------------
module partial_reliability_stop_wait_sender_core import prsw_pkg::*; #(
	parameter int unsigned WINDOW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              max_lost_we,
	input  logic [LOST_W-1:0] max_lost_wdata,
	prsw_in_if.sink           evt_in,
	prsw_out_if.source        res_out
);

	logic advance;
	logic valid_s1;
	evt_t evt_s1;

	// input register
	prsw_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_in   (evt_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.evt_s1   (evt_s1)
	);

	// state, classification and result register
	prsw_engine #(
		.WINDOW (WINDOW)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_lost_we    (max_lost_we),
		.max_lost_wdata (max_lost_wdata),
		.valid_s1       (valid_s1),
		.evt_s1         (evt_s1),
		.advance        (advance),
		.res_out        (res_out)
	);

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the partial reliability stop-and-wait sender.
// A scoreboard tracks sequence bit, loss window, slot and loss count, and
// predicts one result word per event word. A short directed run covers the
// corner cases. Random event sequences then run under several loss limits
// and three idle profiles, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import prsw_pkg::*;

	localparam int unsigned WIN       = 10;
	localparam int unsigned LIMIT_CYC = 400000;
	localparam int unsigned SEG_WORDS = 117;
	localparam int unsigned DRAIN_CYC = 4;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// one predicted result word
	typedef struct {
		action_t           action;
		logic              seq_bit;
		logic [LOST_W-1:0] lost;
	} sender_result_t;

	// tracks sender state and holds predicted result words in order
	class sender_scoreboard;
		bit                seq_bit;
		bit [WIN-1:0]      delivered;
		int unsigned       slot;
		bit [LOST_W-1:0]   lost_cnt;
		bit                waiting;
		bit [LOST_W-1:0]   limit;
		sender_result_t    expq[$];
		int unsigned       errors;

		function new();
			seq_bit   = 1'b0;
			delivered = '1;
			slot      = 0;
			lost_cnt  = '0;
			waiting   = 1'b0;
			limit     = MAX_LOST_RST;
			errors    = 0;
		endfunction

		function void set_limit(input logic [LOST_W-1:0] v);
			limit = v;
		endfunction

		function int unsigned pending();
			return expq.size();
		endfunction

		// a lost slot is counted once; a lost slot turned delivered lowers the count
		function void mark_slot(input bit dlv);
			if (delivered[slot] && !dlv)
				lost_cnt++;
			else if (!delivered[slot] && dlv && lost_cnt != 0)
				lost_cnt--;
			delivered[slot] = dlv;
		endfunction

		function void advance_slot();
			slot = (slot + 1 >= WIN) ? 0 : slot + 1;
		endfunction

		// accepted event word: update state and queue the predicted result
		function void note_event(input logic [MODE_W-1:0] mode, input logic ackn);
			sender_result_t r;
			r.action  = ACT_IGNORED;
			r.seq_bit = 1'b0;
			case (mode)
				MODE_SEND: begin
					if (waiting) begin
						r.action = ACT_BUSY;
					end else begin
						r.action  = ACT_NEW;
						r.seq_bit = seq_bit;
						seq_bit   = ~seq_bit;
						waiting   = 1'b1;
					end
				end
				MODE_ACK: begin
					if (waiting && ackn == seq_bit) begin
						r.action = ACT_DELIVERED;
						mark_slot(1'b1);
						advance_slot();
						waiting = 1'b0;
					end
				end
				MODE_TIMEOUT: begin
					if (waiting) begin
						mark_slot(1'b0);
						if (lost_cnt <= limit) begin
							r.action = ACT_LOSS_OK;
							advance_slot();
							seq_bit = ~seq_bit;
							waiting = 1'b0;
						end else begin
							r.action  = ACT_RETX;
							r.seq_bit = ~seq_bit;
						end
					end
				end
				default: ;
			endcase
			r.lost = lost_cnt;
			expq.push_back(r);
		endfunction

		function void report(input string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		// accepted result word: compare with the oldest prediction
		function void check_result(input action_t action, input logic sb,
				input logic [LOST_W-1:0] lost);
			sender_result_t e;
			if (expq.size() == 0) begin
				report($sformatf("unexpected word action=%0d seq=%0d lost=%0d",
					action, sb, lost));
				return;
			end
			e = expq.pop_front();
			if (action !== e.action || sb !== e.seq_bit || lost !== e.lost)
				report($sformatf("exp action=%0d seq=%0d lost=%0d, got %0d %0d %0d",
					e.action, e.seq_bit, e.lost, action, sb, lost));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              max_lost_we;
	logic [LOST_W-1:0] max_lost_wdata;
	logic              hold_rx;
	int unsigned       src_idle_pct;
	int unsigned       snk_idle_pct;
	int unsigned       cycle_cnt;
	sender_scoreboard  sb;

	prsw_in_if  evt ();
	prsw_out_if res ();

	partial_reliability_stop_wait_sender_core #(
		.WINDOW(WIN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_lost_we   (max_lost_we),
		.max_lost_wdata(max_lost_wdata),
		.evt_in        (evt),
		.res_out       (res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt >= LIMIT_CYC) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// result side: check accepted words, drive ready with random stalls
	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid === 1'b1 && res.ready)
				sb.check_result(res.action, res.seq_bit_out, res.lost_in_window);
			res.ready <= !hold_rx && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// offer one event word, with random idle cycles ahead of it
	task automatic put_event(input logic [MODE_W-1:0] m, input logic a);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			evt.valid <= 1'b0;
			@(posedge clk);
		end
		evt.valid      <= 1'b1;
		evt.mode       <= m;
		evt.ack_number <= a;
		@(posedge clk);
		while (!evt.ready)
			@(posedge clk);
		sb.note_event(m, a);
	endtask

	// stop offering and wait for every predicted word
	task automatic drain();
		evt.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// loss limit write, only with the block idle
	task automatic write_limit(input logic [LOST_W-1:0] v);
		drain();
		max_lost_we    <= 1'b1;
		max_lost_wdata <= v;
		@(posedge clk);
		max_lost_we    <= 1'b0;
		sb.set_limit(v);
	endtask

	// mostly well-formed exchanges, some busy sends, stray acks and unused codes
	task automatic pick_event(output logic [MODE_W-1:0] m, output logic a);
		int unsigned r;
		r = $urandom_range(99);
		a = 1'($urandom_range(1));
		if (sb.waiting) begin
			if (r < 45) begin
				m = MODE_ACK;
				a = sb.seq_bit;
			end else if (r < 75) begin
				m = MODE_TIMEOUT;
			end else if (r < 85) begin
				m = MODE_ACK;
				a = ~sb.seq_bit;
			end else if (r < 93) begin
				m = MODE_SEND;
			end else begin
				m = MODE_UNUSED;
			end
		end else begin
			if (r < 60)
				m = MODE_SEND;
			else if (r < 75)
				m = MODE_TIMEOUT;
			else if (r < 90)
				m = MODE_ACK;
			else
				m = MODE_UNUSED;
		end
	endtask

	task automatic run_segment(input logic [LOST_W-1:0] lim, input bit with_hold);
		logic [MODE_W-1:0] m;
		logic              a;
		write_limit(lim);
		// long receiver hold-off while words keep coming
		if (with_hold) begin
			fork
				begin
					hold_rx <= 1'b1;
					repeat (120) @(posedge clk);
					hold_rx <= 1'b0;
				end
			join_none
		end
		for (int unsigned i = 0; i < SEG_WORDS; i++) begin
			if (i == SEG_WORDS / 2)
				drain();
			pick_event(m, a);
			put_event(m, a);
		end
	endtask

	// main sequence
	initial begin
		logic [LOST_W-1:0] limits [9];
		limits = '{7'd0, 7'd64, 7'd5, 7'd10, 7'd1, 7'd2, 7'd3, 7'd9, 7'd63};
		sb = new();
		arst_n         <= 1'b0;
		max_lost_we    <= 1'b0;
		max_lost_wdata <= '0;
		hold_rx        <= 1'b0;
		evt.valid      <= 1'b0;
		evt.mode       <= MODE_SEND;
		evt.ack_number <= 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// idle-state events, busy send, wrong-bit ack, unused code
		put_event(MODE_ACK, 1'b0);
		put_event(MODE_TIMEOUT, 1'b1);
		put_event(MODE_UNUSED, 1'b1);
		put_event(MODE_SEND, 1'b0);
		put_event(MODE_SEND, 1'b1);
		put_event(MODE_ACK, ~sb.seq_bit);
		put_event(MODE_UNUSED, 1'b0);
		put_event(MODE_ACK, sb.seq_bit);
		// losses up to the reset limit accepted, then retransmission
		repeat (4) begin
			put_event(MODE_SEND, 1'b0);
			put_event(MODE_TIMEOUT, 1'b0);
		end
		// slot already lost is not counted again
		put_event(MODE_TIMEOUT, 1'b1);
		// lost slot overwritten as delivered
		put_event(MODE_ACK, sb.seq_bit);
		// zero limit: every loss retransmits
		write_limit(7'd0);
		put_event(MODE_SEND, 1'b1);
		put_event(MODE_TIMEOUT, 1'b0);
		put_event(MODE_TIMEOUT, 1'b1);
		put_event(MODE_ACK, sb.seq_bit);
		// limit above window: every loss accepted
		write_limit(7'd64);
		put_event(MODE_SEND, 1'b0);
		put_event(MODE_TIMEOUT, 1'b0);
		put_event(MODE_SEND, 1'b0);
		put_event(MODE_ACK, sb.seq_bit);

		// random part: three idle profiles, three limits each
		for (int unsigned p = 0; p < 3; p++) begin
			case (p)
				0: begin
					src_idle_pct = 20;
					snk_idle_pct = 86;
				end
				1: begin
					src_idle_pct = 86;
					snk_idle_pct = 20;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int unsigned k = 0; k < 3; k++)
				run_segment(limits[p * 3 + k], p == 2 && k == 0);
		end

		evt.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
src/prsw_pkg.sv
src/prsw_in_if.sv
src/prsw_out_if.sv
src/prsw_in_stage.sv
src/prsw_engine.sv
src/partial_reliability_stop_wait_sender_core.sv
test/tb_top.sv
